FILE: rtl/pie_pkg.sv
// Shared types and constants for the postfix integer evaluator.
// Holds character codes, status codes, cell and FSM encodings and ALU bundles.
// No dependencies.
package pie_pkg;

    localparam int WORD_W  = 32;               // stack entry width
    localparam int ACC_W   = 31;               // number accumulator, saturates at 2^31-1
    localparam int DEPTH_W = 5;                // width of the depth field
    localparam int STEP_W  = $clog2(WORD_W);   // iteration counter of the mul/div unit

    typedef logic [WORD_W-1:0] word_t;

    localparam logic [ACC_W-1:0] NUM_MAX = '1;

    // character codes
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_SLASH = 8'h2F;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_UNDER = 2'd1,
        STAT_OVER  = 2'd2,
        STAT_DIV0  = 2'd3
    } status_t;

    // per-cell move: keep, take from the cell above (push), take from below (pop)
    typedef enum logic [1:0] {
        CELL_HOLD       = 2'd0,
        CELL_SHIFT_DOWN = 2'd1,
        CELL_SHIFT_UP   = 2'd2
    } cell_op_t;

    typedef enum logic {
        FSM_IDLE   = 1'b0,
        FSM_MULDIV = 1'b1
    } fsm_t;

    typedef struct packed {
        logic start;
        logic is_div;
    } alu_req_t;

    typedef struct packed {
        logic  done;
        word_t result;
    } alu_rsp_t;

endpackage

FILE: rtl/pie_cell.sv
// One entry of the shift-register operand stack.
// Depends on pie_pkg (word_t, cell_op_t).
module pie_cell
    import pie_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  word_t    above,
    input  word_t    below,
    output word_t    value
);

    word_t value_reg;
    word_t value_next;

    always_comb
    begin
        unique case (op)
            CELL_SHIFT_DOWN: value_next = above;
            CELL_SHIFT_UP:   value_next = below;
            default:         value_next = value_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

FILE: rtl/pie_alu.sv
// Iterative multiply / signed divide unit, one bit per cycle.
// Multiply keeps the low word; divide truncates toward zero, divisor non-zero.
// Depends on pie_pkg.
module pie_alu
    import pie_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  alu_req_t req,
    input  word_t    a,
    input  word_t    b,
    output alu_rsp_t rsp
);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              is_div_reg, is_div_next;
    logic              neg_reg, neg_next;
    word_t             x_reg, x_next;     // dividend/quotient or multiplier
    word_t             y_reg, y_next;     // divisor or multiplicand
    logic [WORD_W:0]   acc_reg, acc_next; // remainder or product

    word_t           a_mag;
    word_t           b_mag;
    logic [WORD_W:0] rem_sh;
    logic [WORD_W:0] diff;
    word_t           psum;

    assign a_mag  = a[WORD_W-1] ? (~a + word_t'(1)) : a;
    assign b_mag  = b[WORD_W-1] ? (~b + word_t'(1)) : b;
    assign rem_sh = {acc_reg[WORD_W-1:0], x_reg[WORD_W-1]};
    assign diff   = rem_sh - {1'b0, y_reg};
    assign psum   = acc_reg[WORD_W-1:0] + y_reg;

    always_comb
    begin
        busy_next   = busy_reg;
        done_next   = done_reg;
        step_next   = step_reg;
        is_div_next = is_div_reg;
        neg_next    = neg_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        acc_next    = acc_reg;
        if (req.start)
        begin
            busy_next   = 1'b1;
            done_next   = 1'b0;
            step_next   = '0;
            is_div_next = req.is_div;
            neg_next    = a[WORD_W-1] ^ b[WORD_W-1];
            acc_next    = '0;
            if (req.is_div)
            begin
                x_next = a_mag;
                y_next = b_mag;
            end
            else
            begin
                x_next = b;
                y_next = a;
            end
        end
        else if (busy_reg)
        begin
            if (is_div_reg)
            begin
                if (!diff[WORD_W])
                begin
                    acc_next = diff;
                    x_next   = {x_reg[WORD_W-2:0], 1'b1};
                end
                else
                begin
                    acc_next = rem_sh;
                    x_next   = {x_reg[WORD_W-2:0], 1'b0};
                end
            end
            else
            begin
                if (x_reg[0])
                begin
                    acc_next = {1'b0, psum};
                end
                x_next = {1'b0, x_reg[WORD_W-1:1]};
                y_next = {y_reg[WORD_W-2:0], 1'b0};
            end
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(WORD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        is_div_reg <= is_div_next;
        neg_reg    <= neg_next;
        x_reg      <= x_next;
        y_reg      <= y_next;
        acc_reg    <= acc_next;
    end

    assign rsp.done   = done_reg;
    assign rsp.result = !is_div_reg ? acc_reg[WORD_W-1:0]
                      : (neg_reg ? (~x_reg + word_t'(1)) : x_reg);

endmodule

FILE: rtl/postfix_integer_evaluator.sv
// Postfix (reverse Polish) integer evaluator, top level.
// Depends on pie_pkg, pie_cell (stack entries) and pie_alu (mul/div unit).
//
// Usage
//   Input channel  : in_valid / in_stall carry one beat per character, ch plus
//                    start_req (clears stack and pending number first).
//   Output channel : out_valid / out_stall carry one beat per character:
//                    top_value, depth and status (ok, underflow, overflow,
//                    divide by zero).
//   Sequencing     : digits, spaces, + and -, other characters and any error
//                    case load their beat into the output register on
//                    acceptance; a new character may follow in the very next
//                    cycle unless out_stall holds that beat. * and / run 32
//                    iterations of the shared shift-add / restoring-divide
//                    unit before the result beat; no input is taken meanwhile.
//   Stack          : a row of STACK_DEPTH cells, top in cell 0; a push shifts
//                    every cell down by one, a binary operator shifts up by one
//                    and drops its answer into cell 0.
//   Stall          : one output register; while it holds an untaken beat and
//                    out_stall is high, in_stall is raised. A finished mul/div
//                    waits in the unit until the register frees up.
//   Reset          : rst_n (async, active low) empties the stack, clears the
//                    pending number and drops any output beat.
module postfix_integer_evaluator
    import pie_pkg::*;
#(
    parameter int STACK_DEPTH = 16
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [7:0]               ch,
    input  logic                     start_req,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [WORD_W-1:0] top_value,
    output logic [DEPTH_W-1:0]       depth,
    output logic [1:0]               status
);

    localparam int CNT_W = $clog2(STACK_DEPTH + 1);

    fsm_t             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    logic             dig_reg, dig_next;

    logic               out_valid_reg, out_valid_next;
    word_t              top_reg, top_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    status_t            status_reg, status_next;

    word_t    cell_q [STACK_DEPTH];
    cell_op_t op_top;
    cell_op_t op_rest;
    word_t    top_in;

    alu_req_t alu_req;
    alu_rsp_t alu_rsp;

    logic             accept;
    logic             slot_free;
    logic             load_out;
    logic [CNT_W-1:0] eff_cnt;
    logic [ACC_W-1:0] eff_acc;
    logic             eff_dig;
    logic             is_digit;
    logic [3:0]       digit;
    logic [ACC_W+3:0] acc_x10;
    logic [ACC_W-1:0] acc_sat;
    word_t            top_now;
    word_t            op_a;
    word_t            op_b;

    // ---- operand stack: chain of cells ----
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        word_t    above;
        word_t    below;
        cell_op_t op;

        if (i == 0)
        begin : g_head
            assign above = top_in;
            assign op    = op_top;
        end
        else
        begin : g_body
            assign above = cell_q[i-1];
            assign op    = op_rest;
        end

        if (i == STACK_DEPTH - 1)
        begin : g_tail
            assign below = cell_q[i];
        end
        else
        begin : g_link
            assign below = cell_q[i+1];
        end

        pie_cell u_cell (
            .clk   (clk),
            .op    (op),
            .above (above),
            .below (below),
            .value (cell_q[i])
        );
    end

    pie_alu u_alu (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (alu_req),
        .a     (op_a),
        .b     (op_b),
        .rsp   (alu_rsp)
    );

    // a is second from top, b is top
    assign op_a = cell_q[1];
    assign op_b = cell_q[0];

    // ---- handshake ----
    assign slot_free = !out_valid_reg || !out_stall;
    assign in_stall  = (state_reg != FSM_IDLE) || !slot_free;
    assign accept    = in_valid && !in_stall;

    // start_req clears before the character is handled
    assign eff_cnt = start_req ? '0 : cnt_reg;
    assign eff_acc = start_req ? '0 : acc_reg;
    assign eff_dig = start_req ? 1'b0 : dig_reg;
    assign top_now = (eff_cnt != '0) ? cell_q[0] : '0;

    // acc * 10 + digit, saturating
    assign is_digit = (ch >= CH_ZERO) && (ch <= CH_NINE);
    assign digit    = 4'(ch - CH_ZERO);
    assign acc_x10  = ({4'b0, eff_acc} << 3) + ({4'b0, eff_acc} << 1)
                    + (ACC_W + 4)'(digit);
    assign acc_sat  = (acc_x10 > (ACC_W + 4)'(NUM_MAX)) ? NUM_MAX : acc_x10[ACC_W-1:0];

    always_comb
    begin
        state_next  = state_reg;
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        dig_next    = dig_reg;
        op_top      = CELL_HOLD;
        op_rest     = CELL_HOLD;
        top_in      = {1'b0, eff_acc};
        alu_req     = '0;
        load_out    = 1'b0;
        top_next    = top_now;
        status_next = STAT_OK;

        unique case (state_reg)
            FSM_IDLE:
            begin
                if (accept)
                begin
                    cnt_next = eff_cnt;
                    acc_next = eff_acc;
                    dig_next = eff_dig;
                    load_out = 1'b1;
                    priority if (is_digit)
                    begin
                        acc_next = acc_sat;
                        dig_next = 1'b1;
                    end
                    else if (ch == CH_SPACE)
                    begin
                        if (eff_dig)
                        begin
                            if (eff_cnt != CNT_W'(STACK_DEPTH))
                            begin
                                op_top   = CELL_SHIFT_DOWN;
                                op_rest  = CELL_SHIFT_DOWN;
                                cnt_next = eff_cnt + CNT_W'(1);
                                top_next = {1'b0, eff_acc};
                            end
                            else
                            begin
                                status_next = STAT_OVER;
                            end
                            acc_next = '0;
                            dig_next = 1'b0;
                        end
                    end
                    else if ((ch == CH_PLUS) || (ch == CH_MINUS) ||
                             (ch == CH_STAR) || (ch == CH_SLASH))
                    begin
                        if (eff_cnt < CNT_W'(2))
                        begin
                            status_next = STAT_UNDER;
                        end
                        else if ((ch != CH_SLASH) || (op_b != '0))
                        begin
                            if ((ch == CH_PLUS) || (ch == CH_MINUS))
                            begin
                                top_in   = (ch == CH_PLUS) ? (op_a + op_b) : (op_a - op_b);
                                op_top   = CELL_SHIFT_DOWN;
                                op_rest  = CELL_SHIFT_UP;
                                cnt_next = eff_cnt - CNT_W'(1);
                                top_next = top_in;
                            end
                            else
                            begin
                                // multi-cycle: result beat comes from FSM_MULDIV
                                alu_req.start  = 1'b1;
                                alu_req.is_div = (ch == CH_SLASH);
                                load_out       = 1'b0;
                                state_next     = FSM_MULDIV;
                            end
                        end
                        else
                        begin
                            // divide by zero: pop both, push 0
                            top_in      = '0;
                            op_top      = CELL_SHIFT_DOWN;
                            op_rest     = CELL_SHIFT_UP;
                            cnt_next    = eff_cnt - CNT_W'(1);
                            top_next    = '0;
                            status_next = STAT_DIV0;
                        end
                    end
                    else
                    begin
                        // anything else leaves the state alone
                    end
                end
            end
            FSM_MULDIV:
            begin
                if (alu_rsp.done && slot_free)
                begin
                    top_in     = alu_rsp.result;
                    op_top     = CELL_SHIFT_DOWN;
                    op_rest    = CELL_SHIFT_UP;
                    cnt_next   = cnt_reg - CNT_W'(1);
                    top_next   = alu_rsp.result;
                    load_out   = 1'b1;
                    state_next = FSM_IDLE;
                end
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase

        depth_next     = DEPTH_W'(cnt_next);
        out_valid_next = load_out || (out_valid_reg && out_stall);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            dig_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            dig_reg       <= dig_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload, loaded only with a fresh beat
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            top_reg    <= top_next;
            depth_reg  <= depth_next;
            status_reg <= status_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign top_value = top_reg;
    assign depth     = depth_reg;
    assign status    = status_reg;

endmodule
